### rtl/fcr_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the table-driven Feistel round cipher.
package fcr_pkg;

	localparam int FUNC_W  = 2;
	localparam int ROUND_W = 3;

	// Number of rounds. The round field of a write is ROUND_W bits wide, so the
	// round count is fixed here rather than left open as a module parameter.
	localparam int ROUNDS  = 5;

	// Function codes of an input item. Code 3 has no meaning and yields nothing.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_ENC   = 2'd1,
		FUNC_DEC   = 2'd2
	} fcr_func_t;

	// Control that travels with an item from one round stage to the next.
	typedef struct packed {
		logic               valid;
		fcr_func_t          func;
		logic [ROUND_W-1:0] table_round;
	} fcr_ctrl_t;

endpackage

### rtl/fcr_round.sv
`timescale 1ns / 1ps
// One round stage of the cipher pipeline, holding its own round table memory.
module fcr_round #(
	parameter int HALF_BITS = 8,
	parameter int K         = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fcr_pkg::fcr_ctrl_t    ctrl_in,
	input  logic [HALF_BITS-1:0]  addr_in,
	input  logic [HALF_BITS-1:0]  data_in,
	input  logic [HALF_BITS-1:0]  l_in,
	input  logic [HALF_BITS-1:0]  r_in,
	output fcr_pkg::fcr_ctrl_t    ctrl_out,
	output logic [HALF_BITS-1:0]  addr_out,
	output logic [HALF_BITS-1:0]  data_out,
	output logic [HALF_BITS-1:0]  l_out,
	output logic [HALF_BITS-1:0]  r_out
);
	import fcr_pkg::*;

	localparam int  DEPTH  = 2 * (1 << HALF_BITS);
	// The decryption table of this stage is the one of the mirrored round.
	localparam int  MIRROR = ROUNDS - 1 - K;
	localparam bit  SHARED = (MIRROR == K);
	localparam bit  SWAP   = (K + 1 < ROUNDS);

	// Lower half: table of round K (encryption). Upper half: table of the
	// mirrored round (decryption).
	logic [HALF_BITS-1:0] mem [DEPTH];

	fcr_ctrl_t            ctrl_q;
	logic [HALF_BITS-1:0] addr_q;
	logic [HALF_BITS-1:0] data_q;
	logic [HALF_BITS-1:0] l_q;
	logic [HALF_BITS-1:0] r_q;
	logic [HALF_BITS-1:0] rdata_q;

	logic                 hit_enc;
	logic                 hit_dec;
	logic                 wr_en;
	logic                 wr_sel;
	logic                 rd_sel;
	logic [HALF_BITS-1:0] new_l;

	assign hit_enc = (int'(ctrl_in.table_round) == K);
	assign hit_dec = (int'(ctrl_in.table_round) == MIRROR);
	assign wr_en   = ctrl_in.valid && (ctrl_in.func == FUNC_WRITE) && (hit_enc || hit_dec);
	assign wr_sel  = !hit_enc;
	assign rd_sel  = (ctrl_in.func == FUNC_DEC) && !SHARED;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{wr_sel, addr_in}] <= data_in;
		end
		rdata_q <= mem[{rd_sel, r_in}];
		addr_q  <= addr_in;
		data_q  <= data_in;
		l_q     <= l_in;
		r_q     <= r_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_in;
		end
	end

	assign new_l    = rdata_q ^ l_q;
	assign ctrl_out = ctrl_q;
	assign addr_out = addr_q;
	assign data_out = data_q;
	assign l_out    = SWAP ? r_q : new_l;
	assign r_out    = SWAP ? new_l : r_q;

endmodule

### rtl/feistel_table_round_cipher.sv
`timescale 1ns / 1ps
// Top level of the table-driven Feistel round cipher.
//
// The block takes one item in every clock cycle (busy never rises) and
// passes it through a pipeline of ROUNDS round stages followed by an output
// register, so an encryption or decryption result appears on left_out and
// right_out with done high for one cycle only, once it has passed every
// round stage and the output register. Table writes flow down the same
// pipeline and each stage updates its own memory when the write reaches
// it; every block therefore sees exactly the table contents written by
// items accepted before it, however densely writes and blocks are
// interleaved. The rate of one item per cycle is set by the single read
// port of each stage's round table memory, which serves one round of one
// block per cycle. Table entries hold no value until written and are never
// cleared, so the block is ready straight after reset.
module feistel_table_round_cipher #(
	parameter int HALF_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [fcr_pkg::FUNC_W-1:0]  func,
	input  logic [fcr_pkg::ROUND_W-1:0] table_round,
	input  logic [HALF_BITS-1:0]        table_addr,
	input  logic [HALF_BITS-1:0]        table_data,
	input  logic [HALF_BITS-1:0]        left_half,
	input  logic [HALF_BITS-1:0]        right_half,
	output logic                        done,
	output logic [HALF_BITS-1:0]        left_out,
	output logic [HALF_BITS-1:0]        right_out
);
	import fcr_pkg::*;

	// Signals between the round stages; entry 0 is the input transfer.
	fcr_ctrl_t            ctrl   [ROUNDS+1];
	logic [HALF_BITS-1:0] addr   [ROUNDS+1];
	logic [HALF_BITS-1:0] data   [ROUNDS+1];
	logic [HALF_BITS-1:0] l_half [ROUNDS+1];
	logic [HALF_BITS-1:0] r_half [ROUNDS+1];

	logic                 done_q;
	logic [HALF_BITS-1:0] left_q;
	logic [HALF_BITS-1:0] right_q;
	logic                 result_valid;

	// The pipeline never stalls, so every start is a transfer.
	assign busy = 1'b0;

	assign ctrl[0].valid       = start;
	assign ctrl[0].func        = fcr_func_t'(func);
	assign ctrl[0].table_round = table_round;
	assign addr[0]             = table_addr;
	assign data[0]             = table_data;
	assign l_half[0]           = left_half;
	assign r_half[0]           = right_half;

	for (genvar k = 0; k < ROUNDS; k++) begin : g_round
		fcr_round #(
			.HALF_BITS (HALF_BITS),
			.K         (k)
		) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl_in  (ctrl[k]),
			.addr_in  (addr[k]),
			.data_in  (data[k]),
			.l_in     (l_half[k]),
			.r_in     (r_half[k]),
			.ctrl_out (ctrl[k+1]),
			.addr_out (addr[k+1]),
			.data_out (data[k+1]),
			.l_out    (l_half[k+1]),
			.r_out    (r_half[k+1])
		);
	end

	// Only encryptions and decryptions give a result; writes and the unused
	// function code leave the pipeline silently.
	assign result_valid = ctrl[ROUNDS].valid &&
		(ctrl[ROUNDS].func == FUNC_ENC || ctrl[ROUNDS].func == FUNC_DEC);

	// The write fields are not needed past the last stage.
	logic unused_tail;
	assign unused_tail = ^{addr[ROUNDS], data[ROUNDS], ctrl[ROUNDS].table_round};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= result_valid;
		end
	end

	always_ff @(posedge clk) begin
		left_q  <= l_half[ROUNDS];
		right_q <= r_half[ROUNDS];
	end

	assign done      = done_q;
	assign left_out  = unused_tail ? left_q : left_q;
	assign right_out = right_q;

endmodule

### tb/sv/feistel_table_round_cipher_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the table-driven Feistel round cipher.
module feistel_table_round_cipher_test;

	import fcr_pkg::*;

	localparam int HALF_W       = 8;
	localparam int NUM_ROUNDS   = ROUNDS;
	localparam int TABLE_DEPTH  = 1 << HALF_W;
	// Code 3 of the function field has no meaning; the block must ignore it.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	// Number of random transfers that do real work (writes and blocks).
	localparam int RANDOM_ITEMS = 610;
	// Cycles without any transfer, in either direction, before the run is abandoned.
	// Both the longest sender gap and the time a result takes lie well below it, so this is ample.
	localparam int STALL_LIMIT  = 200;
	// Cap on printed mismatches so that a badly broken block cannot flood the log.
	localparam int MAX_REPORTS  = 40;

	typedef struct packed {
		logic [HALF_W-1:0] left;
		logic [HALF_W-1:0] right;
	} half_pair_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [FUNC_W-1:0]   func;
	logic [ROUND_W-1:0]  table_round;
	logic [HALF_W-1:0]   table_addr;
	logic [HALF_W-1:0]   table_data;
	logic [HALF_W-1:0]   left_half;
	logic [HALF_W-1:0]   right_half;
	logic                done;
	logic [HALF_W-1:0]   left_out;
	logic [HALF_W-1:0]   right_out;

	// Our own copy of the round tables, updated at the edge that accepts each write.
	logic [HALF_W-1:0]   round_table_copy [NUM_ROUNDS][TABLE_DEPTH];
	// Blocks still owed by the cipher, oldest first.
	half_pair_t          expected_blocks [$];
	int                  mismatch_count;
	int                  idle_cycle_count;
	// Most recently written entry, used to aim blocks at freshly written data.
	logic [HALF_W-1:0]   last_write_addr;

	feistel_table_round_cipher #(
		.HALF_BITS(HALF_W)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.table_round(table_round),
		.table_addr (table_addr),
		.table_data (table_data),
		.left_half  (left_half),
		.right_half (right_half),
		.done       (done),
		.left_out   (left_out),
		.right_out  (right_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Five Feistel rounds over our table copy. Encryption walks the tables from
	// round one upwards, decryption from the last round downwards; every round
	// but the final one swaps the halves.
	function automatic half_pair_t feistel_crypt(input logic decrypt,
			input logic [HALF_W-1:0] l_in, input logic [HALF_W-1:0] r_in);
		logic [HALF_W-1:0] l;
		logic [HALF_W-1:0] r;
		logic [HALF_W-1:0] mixed;
		int                rnd;
		half_pair_t        res;
		l = l_in;
		r = r_in;
		for (int k = 0; k < NUM_ROUNDS; k++) begin
			rnd = decrypt ? NUM_ROUNDS - 1 - k : k;
			mixed = round_table_copy[rnd][r] ^ l;
			if (k < NUM_ROUNDS - 1) begin
				l = r;
				r = mixed;
			end else begin
				l = mixed;
			end
		end
		res.left = l;
		res.right = r;
		return res;
	endfunction

	// Offers one item and holds it until the block takes it. The caller must be
	// just past a rising edge. Start is left high, so back-to-back calls give a
	// dense stream; a gap is made only by pause_sender.
	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ROUND_W-1:0] rnd,
			input logic [HALF_W-1:0] addr, input logic [HALF_W-1:0] data,
			input logic [HALF_W-1:0] l, input logic [HALF_W-1:0] r);
		start       <= 1'b1;
		func        <= f;
		table_round <= rnd;
		table_addr  <= addr;
		table_data  <= data;
		left_half   <= l;
		right_half  <= r;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		// The transfer has happened at this edge: bring our model up to date
		// in the same order as the block sees the items.
		if (f == FUNC_WRITE) begin
			if (rnd < NUM_ROUNDS) begin
				round_table_copy[rnd][addr] = data;
				last_write_addr = addr;
			end
		end else if (f == FUNC_ENC || f == FUNC_DEC) begin
			expected_blocks.push_back(feistel_crypt(f == FUNC_DEC, l, r));
		end
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [HALF_W-1:0] exp_val,
			input logic [HALF_W-1:0] act_val);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t ns: %s mismatch, expected 0x%02h, actual 0x%02h",
				$time, what, exp_val, act_val);
	endtask

	// Result checker. Done is sampled at the edge that ends its cycle, so the
	// value seen is the one the block held through that cycle.
	always @(posedge clk) begin
		half_pair_t exp_block;
		if (done === 1'b1) begin
			if (expected_blocks.size() == 0) begin
				report_mismatch("unexpected result, left_out", 8'h00, left_out);
			end else begin
				exp_block = expected_blocks.pop_front();
				if (left_out !== exp_block.left)
					report_mismatch("left_out", exp_block.left, left_out);
				if (right_out !== exp_block.right)
					report_mismatch("right_out", exp_block.right, right_out);
			end
		end
	end

	// Watchdog: any input transfer or any result restarts the count.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			idle_cycle_count <= 0;
		end else if (idle_cycle_count >= STALL_LIMIT) begin
			$display("[feistel_table_round_cipher] ERROR");
			$finish;
		end else begin
			idle_cycle_count <= idle_cycle_count + 1;
		end
	end

	// Every entry must hold a value before any block can read it, so all five
	// tables are filled first. This runs as one unbroken stream to exercise the
	// write path at full rate.
	task automatic test_fill_tables();
		for (int rnd = 0; rnd < NUM_ROUNDS; rnd++)
			for (int a = 0; a < TABLE_DEPTH; a++)
				send_item(FUNC_WRITE, rnd[ROUND_W-1:0], a[HALF_W-1:0],
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
		pause_sender(3);
	endtask

	// Extreme halves through both directions, and extreme table entries.
	task automatic test_extremes();
		send_item(FUNC_WRITE, 3'd0, 8'h00, 8'h00, 8'hFF, 8'hFF);
		send_item(FUNC_WRITE, 3'd4, 8'hFF, 8'hFF, 8'h00, 8'h00);
		send_item(FUNC_ENC, 3'd7, 8'hFF, 8'hFF, 8'h00, 8'h00);
		send_item(FUNC_ENC, 3'd0, 8'h00, 8'h00, 8'hFF, 8'hFF);
		send_item(FUNC_DEC, 3'd7, 8'hFF, 8'hFF, 8'h00, 8'h00);
		pause_sender(2);
		send_item(FUNC_DEC, 3'd0, 8'h00, 8'h00, 8'hFF, 8'hFF);
		send_item(FUNC_ENC, 3'd0, 8'h00, 8'h00, 8'h00, 8'hFF);
		send_item(FUNC_DEC, 3'd0, 8'h00, 8'h00, 8'hFF, 8'h00);
		pause_sender(4);
	endtask

	// A write to a round beyond the last, and the unused function code, must
	// change nothing and yield nothing; a block straight after proves it.
	task automatic test_ignored_items();
		send_item(FUNC_WRITE, 3'd5, 8'h00, 8'hA5, 8'h00, 8'h00);
		send_item(FUNC_WRITE, 3'd7, 8'hFF, 8'h5A, 8'hFF, 8'hFF);
		send_item(FUNC_UNUSED, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(FUNC_UNUSED, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_item(FUNC_ENC, 3'd0, 8'h00, 8'h00, 8'h12, 8'h00);
		send_item(FUNC_DEC, 3'd0, 8'h00, 8'h00, 8'h34, 8'hFF);
		pause_sender(1);
	endtask

	// A block right behind a write must see the new value: encryption reads
	// round one with the right half first, decryption reads the last round.
	task automatic test_write_then_read();
		send_item(FUNC_WRITE, 3'd0, 8'h3C, 8'hC3, 8'h00, 8'h00);
		send_item(FUNC_ENC, 3'd0, 8'h00, 8'h00, 8'h77, 8'h3C);
		send_item(FUNC_WRITE, 3'd4, 8'h81, 8'h18, 8'h00, 8'h00);
		send_item(FUNC_DEC, 3'd0, 8'h00, 8'h00, 8'h66, 8'h81);
		send_item(FUNC_WRITE, 3'd4, 8'h81, 8'h99, 8'h00, 8'h00);
		send_item(FUNC_DEC, 3'd0, 8'h00, 8'h00, 8'h66, 8'h81);
		pause_sender(2);
	endtask

	// Decrypting a ciphertext must give back the plaintext.
	task automatic test_round_trip();
		half_pair_t ct;
		ct = feistel_crypt(1'b0, 8'hC0, 8'hDE);
		send_item(FUNC_ENC, 3'd0, 8'h00, 8'h00, 8'hC0, 8'hDE);
		send_item(FUNC_DEC, 3'd0, 8'h00, 8'h00, ct.left, ct.right);
		pause_sender(3);
	endtask

	// Random mix in bursts: mostly blocks, a fair share of writes to live
	// entries, a little noise, and blocks aimed at the entry just written.
	task automatic test_random_mix();
		int          items_sent;
		int          burst_left;
		int          pick;
		logic        decrypt;
		logic [7:0]  l;
		logic [7:0]  r;
		half_pair_t  ct;
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			burst_left = $urandom_range(1, 24);
			while (burst_left > 0 && items_sent < RANDOM_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 22) begin
					send_item(FUNC_WRITE, 3'($urandom_range(0, NUM_ROUNDS - 1)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
					items_sent++;
				end else if (pick < 25) begin
					send_item(FUNC_UNUSED, 3'($urandom_range(0, 7)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				end else if (pick < 28) begin
					send_item(FUNC_WRITE, 3'($urandom_range(NUM_ROUNDS, 7)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				end else begin
					decrypt = 1'($urandom_range(0, 1));
					l = 8'($urandom_range(0, 255));
					r = ($urandom_range(0, 9) < 4) ? last_write_addr :
						8'($urandom_range(0, 255));
					send_item(decrypt ? FUNC_DEC : FUNC_ENC, 3'($urandom_range(0, 7)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), l, r);
					items_sent++;
					if (!decrypt && $urandom_range(0, 9) == 0) begin
						ct = feistel_crypt(1'b0, l, r);
						send_item(FUNC_DEC, 3'($urandom_range(0, 7)),
							8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
							ct.left, ct.right);
						items_sent++;
					end
				end
				burst_left--;
			end
			// A quarter of the bursts run straight into the next one.
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 10));
		end
		pause_sender(1);
	endtask

	initial begin
		arst_n           <= 1'b0;
		start            <= 1'b0;
		func             <= FUNC_WRITE;
		table_round      <= '0;
		table_addr       <= '0;
		table_data       <= '0;
		left_half        <= '0;
		right_half       <= '0;
		mismatch_count   = 0;
		idle_cycle_count = 0;
		last_write_addr  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_tables();
		test_extremes();
		test_ignored_items();
		test_write_then_read();
		test_round_trip();
		test_random_mix();

		// Drain: the watchdog catches any result that never turns up.
		while (expected_blocks.size() != 0)
			@(posedge clk);
		repeat (NUM_ROUNDS + 4) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("[feistel_table_round_cipher] OK");
		end else begin
			$display("[feistel_table_round_cipher] ERROR");
		end
		$finish;
	end

endmodule
